FILE: rtl/bns_pkg.sv
// Shared types, constants and the random byte function of the bigram name sampler.
package bns_pkg;

  localparam int VOCAB_DEF = 27;

  localparam logic [7:0] RNG_INIT    = 8'h5A;
  localparam logic [7:0] RETRY_RESET = 8'd255;
  localparam logic [7:0] CHAR_BASE   = 8'h60;
  localparam logic [7:0] CHAR_NONE   = 8'h00;
  localparam logic [2:0] LEN_SHORT   = 3'd3;
  localparam logic [2:0] LEN_LONG    = 3'd4;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_GEN   = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [4:0] row;
    logic [4:0] col;
    logic [7:0] count;
  } bns_req_t;

  typedef struct packed {
    logic [7:0] char_first;
    logic [7:0] char_second;
    logic [7:0] char_third;
    logic [7:0] char_fourth;
    logic [2:0] name_length;
  } bns_rsp_t;

  function automatic logic [7:0] rng_step(input logic [7:0] v, input logic [7:0] cnt);
    logic [7:0] t;
    t = v ^ (v << 1);
    t = t ^ (t >> 1);
    t = t ^ (t << 2);
    t = t ^ cnt;
    if (t == 8'd0) begin
      t = 8'd1;
    end
    return t;
  endfunction

endpackage

FILE: rtl/bigram_name_sampler.sv
// Bigram name sampler: count table memory, random draw walker and name assembly.
//
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  bns_req_t (table write or generate)
// rsp       out        rsp_valid / rsp_ready  bns_rsp_t (one per generate)
// retry     in         retry_we               retry_wdata (retry limit)
//
// Each draw makes a random byte, then walks one table row through the single read
// port, one count per cycle. A name takes four draws, plus one draw for each retry.
// Reset loads the generator and the retry limit; table contents stay unknown.
// A finished name waits in the output register; a stalled rsp holds the next name.
module bigram_name_sampler #(
  parameter int VOCAB = bns_pkg::VOCAB_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  bns_pkg::bns_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output bns_pkg::bns_rsp_t rsp,
  input  logic              retry_we,
  input  logic [7:0]        retry_wdata
);
  import bns_pkg::*;

  localparam int IW    = (VOCAB > 1) ? $clog2(VOCAB) : 1;
  localparam int DEPTH = VOCAB * VOCAB;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = AW + 6;
  localparam logic [IW-1:0] LAST = IW'(VOCAB - 1);
  localparam logic [IW-1:0] IDX_A = IW'(1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SEED = 4'b0010,
    S_WALK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t          state;
  logic [7:0]      mem [DEPTH];
  logic [7:0]      q;
  logic [7:0]      retry_limit;
  logic [7:0]      rng_value;
  logic [7:0]      rng_count;
  logic [7:0]      rnd;
  logic [7:0]      sum;
  logic [7:0]      sum_next;
  logic [7:0]      tries;
  logic [7:0]      tries_next;
  logic [IW-1:0]   cur;
  logic [IW-1:0]   rd_k;
  logic [IW-1:0]   dk;
  logic [IW-1:0]   pick;
  logic            rd_on;
  logic            dv;
  logic            hit;
  logic [1:0]      letter_n;
  logic [7:0]      c1;
  logic [7:0]      c2;
  logic [7:0]      c3;
  logic [7:0]      c4;
  logic [2:0]      len;
  logic [7:0]      cnt_next;
  logic [7:0]      rnd_next;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   waddr;
  logic            wr_en;
  logic            accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign wr_en     = accept && (req.kind == KIND_WRITE) &&
                     (int'(req.row) < VOCAB) && (int'(req.col) < VOCAB);
  assign waddr     = AW'(WW'(req.row) * WW'(VOCAB) + WW'(req.col));
  assign raddr     = AW'(WW'(cur) * WW'(VOCAB) + WW'(rd_k));

  assign sum_next   = sum + q;
  assign hit        = (rnd < sum_next) || (dk == LAST);
  assign tries_next = tries + 8'd1;
  assign pick       = (dk == '0) ? IDX_A : dk;
  assign cnt_next   = rng_count + 8'd1;
  assign rnd_next   = rng_step(rng_value, cnt_next);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= req.count;
    end
    q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= RETRY_RESET;
    end else if (retry_we) begin
      retry_limit <= retry_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rng_value <= RNG_INIT;
      rng_count <= 8'd0;
      rsp_valid <= 1'b0;
      rd_on     <= 1'b0;
      dv        <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (req.kind == KIND_GEN)) begin
            cur      <= '0;
            tries    <= 8'd0;
            letter_n <= 2'd0;
            state    <= S_SEED;
          end
        end
        S_SEED: begin
          rng_count <= cnt_next;
          rng_value <= rnd_next;
          rnd       <= rnd_next;
          sum       <= 8'd0;
          rd_k      <= '0;
          rd_on     <= 1'b1;
          dv        <= 1'b0;
          state     <= S_WALK;
        end
        S_WALK: begin
          dk <= rd_k;
          if (dv && hit) begin
            rd_on <= 1'b0;
            dv    <= 1'b0;
            if (letter_n == 2'd3) begin
              c4    <= (dk == '0) ? CHAR_NONE : CHAR_BASE + 8'(dk);
              len   <= (dk == '0) ? LEN_SHORT : LEN_LONG;
              state <= S_DONE;
            end else if ((dk == '0) && (tries_next < retry_limit)) begin
              tries <= tries_next;
              cur   <= '0;
              state <= S_SEED;
            end else begin
              case (letter_n)
                2'd0:    c1 <= CHAR_BASE + 8'(pick);
                2'd1:    c2 <= CHAR_BASE + 8'(pick);
                default: c3 <= CHAR_BASE + 8'(pick);
              endcase
              cur      <= pick;
              tries    <= 8'd0;
              letter_n <= letter_n + 2'd1;
              state    <= S_SEED;
            end
          end else begin
            dv <= rd_on;
            if (dv) begin
              sum <= sum_next;
            end
            if (rd_on) begin
              if (rd_k == LAST) begin
                rd_on <= 1'b0;
              end else begin
                rd_k <= rd_k + IW'(1);
              end
            end
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.char_first  <= c1;
            rsp.char_second <= c2;
            rsp.char_third  <= c3;
            rsp.char_fourth <= c4;
            rsp.name_length <= len;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
